[src/gres_pkg.sv]
// ----------------------------------------------------------------------------
// gres_pkg
// Shared types, constants and helpers for the grid ray edge step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gres_pkg;

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int OFF_BITS     = FRAC_BITS + 1;
    localparam int TRIG_BITS    = FRAC_BITS + 8;
    localparam int STAN_BITS    = FRAC_BITS + 2;
    localparam int PATH_BITS    = FRAC_BITS + 1;
    localparam int PROD_BITS    = OFF_BITS + TRIG_BITS;
    localparam int RND_BITS     = PROD_BITS + 1 - FRAC_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = TRIG_BITS;

    localparam int ONE_INT = 1 << FRAC_BITS;
    localparam logic [OFF_BITS-1:0] ONE_FX = OFF_BITS'(ONE_INT);

    // action codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_SPAWN = 2'd2;

    // pixel edges
    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_LEFT   = 2'd3;

    // spawn sectors
    localparam logic [1:0] SECT_SOUTH = 2'd0;
    localparam logic [1:0] SECT_EAST  = 2'd1;
    localparam logic [1:0] SECT_NORTH = 2'd2;
    localparam logic [1:0] SECT_WEST  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUADRANT     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAN_ALPHA    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COT_ALPHA    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CSC_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEC_ALPHA    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPAWN_SECTOR = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPAWN_TAN    = 3'd6;

    // sqrt(2) in Q8.16, truncated
    localparam logic [TRIG_BITS-1:0] RST_TRIG_ONE = TRIG_BITS'(ONE_INT);
    localparam logic [TRIG_BITS-1:0] RST_SQRT2    = TRIG_BITS'(92681);

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic [1:0]                   entry_edge;
        logic [OFF_BITS-1:0]          entry_offset;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left_x;
        logic signed [COORD_BITS-1:0] left_y;
        logic [PATH_BITS-1:0]         path_length;
        logic                         bad_entry;
    } t_out_item;

    typedef struct packed {
        logic [1:0]                  quadrant;
        logic [TRIG_BITS-1:0]        tan_alpha;
        logic [TRIG_BITS-1:0]        cot_alpha;
        logic [TRIG_BITS-1:0]        csc_alpha;
        logic [TRIG_BITS-1:0]        sec_alpha;
        logic [1:0]                  spawn_sector;
        logic signed [STAN_BITS-1:0] spawn_tan;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic [1:0]            cur_edge;
        logic [OFF_BITS-1:0]   cur_offset;
    } t_state;

    // round to nearest at FRAC_BITS, half rounds up
    function automatic logic [RND_BITS-1:0] round_fx(input logic [PROD_BITS-1:0] p);
        logic [PROD_BITS:0] sum;
        sum = {1'b0, p} + (PROD_BITS+1)'(ONE_INT >> 1);
        return sum[PROD_BITS:FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

[src/gres_step_calc.sv]
// ----------------------------------------------------------------------------
// gres_step_calc
// Next-state and result datapath for load, spawn and step actions.
// ----------------------------------------------------------------------------
`default_nettype none

module gres_step_calc (
    input  wire gres_pkg::t_in_item  i_item,
    input  wire gres_pkg::t_cfg      i_cfg,
    input  wire gres_pkg::t_state    i_state,
    output gres_pkg::t_state         o_state,
    output gres_pkg::t_out_item      o_result
);
    import gres_pkg::*;

    localparam int NOFF_BITS = RND_BITS + 2;
    localparam int SPW_BITS  = STAN_BITS + 2;

    logic                        goes_left;
    logic                        goes_up;
    logic [1:0]                  h_entry;
    logic [1:0]                  v_entry;
    logic [OFF_BITS-1:0]         off;
    logic [OFF_BITS-1:0]         px;
    logic [OFF_BITS-1:0]         py;
    logic [OFF_BITS-1:0]         a1;
    logic [OFF_BITS-1:0]         b2;
    logic [PROD_BITS-1:0]        pc1;
    logic [PROD_BITS-1:0]        pc2;
    logic [PROD_BITS-1:0]        pb1;
    logic [PROD_BITS-1:0]        pa2;
    logic [RND_BITS-1:0]         b1;
    logic [RND_BITS-1:0]         a2;
    logic [RND_BITS-1:0]         path_raw;
    logic                        take_h;
    logic signed [NOFF_BITS-1:0] newoff;
    logic [OFF_BITS-1:0]         newoff_clamped;
    t_state                      step_state;
    logic                        flip_neg;
    logic signed [SPW_BITS-1:0]  spw_sum;
    logic [SPW_BITS-1:0]         spw_clamped;
    t_state                      spawn_state;

    // ---------------- step ----------------
    assign goes_left = i_cfg.quadrant[1];
    assign goes_up   = i_cfg.quadrant[1] ^ i_cfg.quadrant[0];
    assign h_entry   = goes_left ? EDGE_RIGHT : EDGE_LEFT;
    assign v_entry   = goes_up ? EDGE_BOTTOM : EDGE_TOP;
    assign off       = (i_state.cur_offset > ONE_FX) ? ONE_FX : i_state.cur_offset;

    always_comb begin
        unique case (i_state.cur_edge)
            EDGE_TOP: begin
                px = off;
                py = '0;
            end
            EDGE_BOTTOM: begin
                px = off;
                py = ONE_FX;
            end
            EDGE_LEFT: begin
                px = '0;
                py = off;
            end
            default: begin
                px = ONE_FX;
                py = off;
            end
        endcase
    end

    assign a1 = goes_left ? px : ONE_FX - px;
    assign b2 = goes_up ? py : ONE_FX - py;

    // four parallel multiplies by per-ray constants
    assign pc1 = PROD_BITS'(a1) * PROD_BITS'(i_cfg.csc_alpha);
    assign pc2 = PROD_BITS'(b2) * PROD_BITS'(i_cfg.sec_alpha);
    assign pb1 = PROD_BITS'(a1) * PROD_BITS'(i_cfg.cot_alpha);
    assign pa2 = PROD_BITS'(b2) * PROD_BITS'(i_cfg.tan_alpha);

    assign b1 = round_fx(pb1);
    assign a2 = round_fx(pa2);

    // tie goes to the vertical edge
    assign take_h   = pc1 < pc2;
    assign path_raw = round_fx(take_h ? pc1 : pc2);

    always_comb begin
        if (take_h) begin
            newoff = goes_up ? $signed(NOFF_BITS'(py)) - $signed(NOFF_BITS'(b1))
                             : $signed(NOFF_BITS'(py)) + $signed(NOFF_BITS'(b1));
        end else begin
            newoff = goes_left ? $signed(NOFF_BITS'(px)) - $signed(NOFF_BITS'(a2))
                               : $signed(NOFF_BITS'(px)) + $signed(NOFF_BITS'(a2));
        end
    end

    always_comb begin
        if (newoff < 0) begin
            newoff_clamped = '0;
        end else if (newoff > $signed(NOFF_BITS'(ONE_FX))) begin
            newoff_clamped = ONE_FX;
        end else begin
            newoff_clamped = newoff[OFF_BITS-1:0];
        end
    end

    always_comb begin
        step_state            = i_state;
        step_state.cur_offset = newoff_clamped;
        if (take_h) begin
            step_state.cur_x    = goes_left ? i_state.cur_x - 1'b1 : i_state.cur_x + 1'b1;
            step_state.cur_edge = h_entry;
        end else begin
            step_state.cur_y    = goes_up ? i_state.cur_y - 1'b1 : i_state.cur_y + 1'b1;
            step_state.cur_edge = v_entry;
        end
    end

    assign o_result.left_x      = i_state.cur_x;
    assign o_result.left_y      = i_state.cur_y;
    assign o_result.path_length = (path_raw > RND_BITS'({PATH_BITS{1'b1}}))
                                ? {PATH_BITS{1'b1}} : path_raw[PATH_BITS-1:0];
    assign o_result.bad_entry   = (i_state.cur_edge != h_entry) &&
                                  (i_state.cur_edge != v_entry);

    // ---------------- spawn ----------------
    assign flip_neg = i_cfg.spawn_sector[1] ^ i_cfg.spawn_sector[0];
    assign spw_sum  = flip_neg
                    ? $signed(SPW_BITS'(ONE_FX)) - SPW_BITS'(i_cfg.spawn_tan)
                    : $signed(SPW_BITS'(ONE_FX)) + SPW_BITS'(i_cfg.spawn_tan);

    always_comb begin
        if (spw_sum < 0) begin
            spw_clamped = '0;
        end else if (spw_sum > $signed(SPW_BITS'(2 * ONE_INT))) begin
            spw_clamped = SPW_BITS'(2 * ONE_INT);
        end else begin
            spw_clamped = spw_sum;
        end
    end

    always_comb begin
        spawn_state.cur_x      = i_item.pixel_x;
        spawn_state.cur_y      = i_item.pixel_y;
        spawn_state.cur_offset = spw_clamped[OFF_BITS:1];
        unique case (i_cfg.spawn_sector)
            SECT_SOUTH: begin
                spawn_state.cur_y    = i_item.pixel_y + 1'b1;
                spawn_state.cur_edge = EDGE_TOP;
            end
            SECT_EAST: begin
                spawn_state.cur_x    = i_item.pixel_x + 1'b1;
                spawn_state.cur_edge = EDGE_LEFT;
            end
            SECT_NORTH: begin
                spawn_state.cur_y    = i_item.pixel_y - 1'b1;
                spawn_state.cur_edge = EDGE_BOTTOM;
            end
            default: begin
                spawn_state.cur_x    = i_item.pixel_x - 1'b1;
                spawn_state.cur_edge = EDGE_RIGHT;
            end
        endcase
    end

    // ---------------- next state select ----------------
    always_comb begin
        unique case (i_item.action)
            ACT_LOAD: begin
                o_state.cur_x      = i_item.pixel_x;
                o_state.cur_y      = i_item.pixel_y;
                o_state.cur_edge   = i_item.entry_edge;
                o_state.cur_offset = (i_item.entry_offset > ONE_FX)
                                   ? ONE_FX : i_item.entry_offset;
            end
            ACT_STEP:  o_state = step_state;
            ACT_SPAWN: o_state = spawn_state;
            default:   o_state = i_state;
        endcase
    end

endmodule

`default_nettype wire

[src/grid_ray_edge_step_unit.sv]
// ----------------------------------------------------------------------------
// grid_ray_edge_step_unit
// Steps one ray through a unit pixel grid, one pixel edge per step action.
// ----------------------------------------------------------------------------
// a step's input is captured in the input register and its result in the output register
// throughput: one transaction per cycle while a step is not held by an output stall; the state
// update (four parallel multiplies, the edge compare) sits between input and output registers
// reset: synchronous active-low; clears position state, config to defaults,
// and both valid flags
`default_nettype none

module grid_ray_edge_step_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire gres_pkg::t_in_item             i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output gres_pkg::t_out_item                 o_out_data,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [gres_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire [gres_pkg::CFG_DAT_BITS-1:0]    i_cfg_data
);
    import gres_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_state    r_state;
    t_cfg      r_cfg;

    t_state    n_state;
    t_out_item n_result;
    logic      out_free;
    logic      is_step;
    logic      proc;

    gres_step_calc u_calc (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_step    = (r_in.action == ACT_STEP);
    // load and spawn never wait on the output side
    assign proc       = r_in_valid && (out_free || !is_step);
    assign o_in_stall = r_in_valid && !proc;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state             <= '0;
            r_cfg.quadrant      <= '0;
            r_cfg.tan_alpha     <= RST_TRIG_ONE;
            r_cfg.cot_alpha     <= RST_TRIG_ONE;
            r_cfg.csc_alpha     <= RST_SQRT2;
            r_cfg.sec_alpha     <= RST_SQRT2;
            r_cfg.spawn_sector  <= '0;
            r_cfg.spawn_tan     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (proc && is_step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_QUADRANT:     r_cfg.quadrant     <= i_cfg_data[1:0];
                    CFG_TAN_ALPHA:    r_cfg.tan_alpha    <= i_cfg_data;
                    CFG_COT_ALPHA:    r_cfg.cot_alpha    <= i_cfg_data;
                    CFG_CSC_ALPHA:    r_cfg.csc_alpha    <= i_cfg_data;
                    CFG_SEC_ALPHA:    r_cfg.sec_alpha    <= i_cfg_data;
                    CFG_SPAWN_SECTOR: r_cfg.spawn_sector <= i_cfg_data[1:0];
                    CFG_SPAWN_TAN:    r_cfg.spawn_tan    <= i_cfg_data[STAN_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (proc && is_step) begin
            r_out <= n_result;
        end
    end

endmodule

`default_nettype wire
